// File: design/csmv_pkg.sv
// shared types and constants for the csr sparse matrix-vector multiply block
// no dependencies; imported by every module of the block except csmv_ram

package csmv_pkg;

	// dense vector store
	localparam int VECTOR_DEPTH = 1024;
	localparam int VEC_AW       = $clog2(VECTOR_DEPTH);
	localparam int VAL_W        = 32;

	// input field widths
	localparam int KIND_W = 2;
	localparam int POS_W  = 10;

	// row sums and row numbering
	localparam int      SUM_W     = 64;
	localparam longint  MAX_ROWS  = 65536;
	localparam int      ROW_W     = $clog2(MAX_ROWS);
	localparam int      ROW_NUM_W = 16;

	// front-to-back op queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD    = 2'd0,
		KIND_NONZERO = 2'd1,
		KIND_EMPTY   = 2'd2,
		KIND_NEW     = 2'd3
	} kind_t;

	// one classified op handed from front to back
	typedef struct packed {
		kind_t                    kind;
		logic                     last;
		logic signed [SUM_W-1:0]  product;
	} csmv_op_t;

endpackage

// File: design/csmv_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module csmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/csmv_front.sv
// front end: accepts input transactions, writes the vector store, gathers
// the vector element for each nonzero and forms the exact Q32.32 product
// depends on csmv_pkg and csmv_ram

module csmv_front import csmv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [KIND_W-1:0]       kind,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] operand_value,
	input  logic                    row_end,
	input  logic [QCNT_W-1:0]       queue_count,
	output logic                    push,
	output csmv_op_t                push_op
);

	logic                    accept;
	kind_t                   in_kind;
	logic                    in_range;
	logic [VEC_AW-1:0]       vec_addr;
	logic [VAL_W-1:0]        vec_data;
	logic [QCNT_W:0]         inflight;

	logic                    valid_s1;
	kind_t                   kind_s1;
	logic                    last_s1;
	logic                    zero_s1;
	logic signed [VAL_W-1:0] value_s1;
	logic signed [VAL_W-1:0] gathered;

	logic                    valid_s2;
	kind_t                   kind_s2;
	logic                    last_s2;
	logic signed [SUM_W-1:0] product_s2;

	// every item in the two stages already holds a reserved queue slot
	assign inflight = {1'b0, queue_count} + (QCNT_W + 1)'(valid_s1)
		+ (QCNT_W + 1)'(valid_s2);
	assign in_stall = inflight >= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept   = in_valid && !in_stall;
	assign in_kind  = kind_t'(kind);
	assign in_range = 32'(position) < 32'(VECTOR_DEPTH);
	assign vec_addr = VEC_AW'(position);

	csmv_ram #(
		.WIDTH (VAL_W),
		.DEPTH (VECTOR_DEPTH)
	) u_vec_ram (
		.clk     (clk),
		.wr_en   (accept && in_kind == KIND_LOAD && in_range),
		.wr_addr (vec_addr),
		.wr_data (operand_value),
		.rd_en   (accept && in_kind == KIND_NONZERO),
		.rd_addr (vec_addr),
		.rd_data (vec_data)
	);

	// index past the store reads as zero
	assign gathered = zero_s1 ? '0 : $signed(vec_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept && in_kind != KIND_LOAD;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= in_kind;
			last_s1  <= row_end && in_kind == KIND_NONZERO;
			zero_s1  <= !in_range;
			value_s1 <= operand_value;
		end
		if (valid_s1) begin
			kind_s2    <= kind_s1;
			last_s2    <= last_s1;
			product_s2 <= value_s1 * gathered;
		end
	end

	assign push            = valid_s2;
	assign push_op.kind    = kind_s2;
	assign push_op.last    = last_s2;
	assign push_op.product = product_s2;

endmodule

// File: design/csmv_queue.sv
// short register queue of classified ops between front and back
// depends on csmv_pkg

module csmv_queue import csmv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csmv_op_t          push_op,
	input  logic              pop,
	output logic              head_valid,
	output csmv_op_t          head_op,
	output logic [QCNT_W-1:0] count
);

	csmv_op_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	assign head_valid = count_q != '0;
	assign head_op    = entry_q[rd_ptr_q];
	assign count      = count_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < QCNT_W'(QUEUE_DEPTH))
		else $error("op queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("op queue read while empty");
`endif

endmodule

// File: design/csmv_back.sv
// back end: saturating row accumulation, row counting and the result register
// depends on csmv_pkg

module csmv_back import csmv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  csmv_op_t                head_op,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SUM_W-1:0] row_sum,
	output logic [ROW_NUM_W-1:0]    row_number
);

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

	logic signed [SUM_W-1:0] sum_q;
	logic [ROW_W-1:0]        row_cnt_q;
	logic [ROW_W-1:0]        row_cnt_next;
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] row_sum_q;
	logic [ROW_NUM_W-1:0]    row_number_q;

	logic [SUM_W:0]          sum_wide;
	logic signed [SUM_W-1:0] sat_sum;
	logic signed [SUM_W-1:0] emit_sum;
	logic                    emits;

	always_comb begin
		sum_wide = {sum_q[SUM_W-1], sum_q} + {head_op.product[SUM_W-1], head_op.product};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sat_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sat_sum = sum_wide[SUM_W-1:0];
		end
	end

	assign emits = head_valid && (head_op.kind == KIND_EMPTY
		|| (head_op.kind == KIND_NONZERO && head_op.last));
	assign emit_sum = (head_op.kind == KIND_NONZERO) ? sat_sum : sum_q;
	// a row-ending op waits only when the result register is held
	assign pop = head_valid && (!emits || !out_valid_q || !out_stall);
	assign row_cnt_next = (row_cnt_q == ROW_W'(MAX_ROWS - 1)) ? '0 : row_cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_q       <= '0;
			row_cnt_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (head_op.kind)
					KIND_NONZERO: begin
						if (head_op.last) begin
							sum_q       <= '0;
							row_cnt_q   <= row_cnt_next;
							out_valid_q <= 1'b1;
						end else begin
							sum_q <= sat_sum;
						end
					end
					KIND_EMPTY: begin
						sum_q       <= '0;
						row_cnt_q   <= row_cnt_next;
						out_valid_q <= 1'b1;
					end
					KIND_NEW: begin
						sum_q     <= '0;
						row_cnt_q <= '0;
					end
					KIND_LOAD: begin
						// loads never reach the queue
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			row_sum_q    <= emit_sum;
			row_number_q <= ROW_NUM_W'(row_cnt_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign row_sum    = row_sum_q;
	assign row_number = row_number_q;

`ifndef SYNTHESIS
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop && emits |=> out_valid_q)
		else $error("finished row did not reach the result register");

	a_new_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_op.kind == KIND_NEW |=> sum_q == '0 && row_cnt_q == '0)
		else $error("matrix start did not clear sum and row count");
`endif

endmodule

// File: design/csr_sparse_matrix_vector_multiply_top.sv
// top level of the csr sparse matrix-vector multiply block
// depends on csmv_pkg, csmv_front, csmv_queue and csmv_back
//
//   channel  handshake             payload
//   input    in_valid / in_stall   kind, position, operand_value, row_end
//   output   out_valid / out_stall row_sum, row_number
//
// one input transaction per cycle sustained while in_stall is low; the vector store ram
// has one write and one read port, so loads and nonzeros both pass at full rate
// a row's ending transaction, once accepted, passes the ram read at the accepting edge,
// then the multiply register, the op queue and the result register
// after reset the sum and row count are zero; the vector store is not cleared
// in_stall rises once the two front stages and the four-entry op queue hold
// four transactions between them, which happens only while out_stall holds a finished row

module csr_sparse_matrix_vector_multiply_top import csmv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [KIND_W-1:0]       kind,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] operand_value,
	input  logic                    row_end,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SUM_W-1:0] row_sum,
	output logic [ROW_NUM_W-1:0]    row_number
);

	logic              push;
	csmv_op_t          push_op;
	logic              pop;
	logic              head_valid;
	csmv_op_t          head_op;
	logic [QCNT_W-1:0] queue_count;

	csmv_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.position      (position),
		.operand_value (operand_value),
		.row_end       (row_end),
		.queue_count   (queue_count),
		.push          (push),
		.push_op       (push_op)
	);

	csmv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op),
		.count      (queue_count)
	);

	csmv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_sum    (row_sum),
		.row_number (row_number)
	);

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for csr_sparse_matrix_vector_multiply_top
// depends on csmv_pkg and the design under design/; a directed table, then random csr traffic
// every finished row is checked against a local row-sum predictor or a typed-in table result

`timescale 1ns / 100ps

module tb_top;
	import csmv_pkg::*;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [ROW_NUM_W-1:0]    num;
	} row_result_t;

	// directed row: stimulus plus an optional typed-in result
	typedef struct packed {
		kind_t                k;
		logic [POS_W-1:0]     p;
		logic [VAL_W-1:0]     v;
		logic                 e;
		logic                 typed;
		logic [SUM_W-1:0]     sum;
		logic [ROW_NUM_W-1:0] num;
	} table_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	kind_t                   kind;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] operand_value;
	logic                    row_end;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [SUM_W-1:0] row_sum;
	logic [ROW_NUM_W-1:0]    row_number;

	// predictor state
	logic signed [VAL_W-1:0] vec_shadow [VECTOR_DEPTH];
	bit                      vec_written [VECTOR_DEPTH];
	logic [POS_W-1:0]        written_cols [$];
	longint                  acc_sum;
	longint                  rows_done;

	row_result_t pending_rows [$];
	int          faults;
	int          sent;
	bit          calm;
	bit          tail;

	table_row_t check_table [26] = '{
		'{KIND_EMPTY,   10'h3FF, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'h0, 16'd0},
		'{KIND_LOAD,    10'h000, 32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_LOAD,    10'h3FF, 32'h8000_0000, 1'b1, 1'b0, 64'h0, 16'd0},
		'{KIND_LOAD,    10'h001, 32'h0001_0000, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_LOAD,    10'h002, 32'hFFFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h3FF, 32'h8000_0000, 1'b1, 1'b1, 64'h4000_0000_0000_0000, 16'd1},
		// positive saturation
		'{KIND_NONZERO, 10'h000, 32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h3FF, 32'h8000_0000, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h3FF, 32'h8000_0000, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 16'd2},
		// negative saturation
		'{KIND_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 16'd3},
		// clamp happens per addition, so a later positive term lifts off the floor
		'{KIND_NONZERO, 10'h000, 32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h000, 32'h7FFF_FFFF, 1'b1, 1'b0, 64'h0, 16'd0},
		'{KIND_LOAD,    10'h2AA, 32'h1234_5678, 1'b1, 1'b0, 64'h0, 16'd0},
		'{KIND_NONZERO, 10'h2AA, 32'h0001_0000, 1'b1, 1'b0, 64'h0, 16'd0},
		'{KIND_EMPTY,   10'h155, 32'h5555_5555, 1'b1, 1'b1, 64'h0, 16'd6},
		// empty row flushes a pending partial sum
		'{KIND_NONZERO, 10'h002, 32'hFFFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_EMPTY,   10'h000, 32'h0000_0000, 1'b0, 1'b1, 64'h1, 16'd7},
		// new matrix drops the partial row and restarts numbering
		'{KIND_NONZERO, 10'h002, 32'hFFFF_FFFF, 1'b0, 1'b0, 64'h0, 16'd0},
		'{KIND_NEW,     10'h3FF, 32'h7FFF_FFFF, 1'b1, 1'b0, 64'h0, 16'd0},
		'{KIND_EMPTY,   10'h2AA, 32'hAAAA_AAAA, 1'b0, 1'b1, 64'h0, 16'd0}
	};

	csr_sparse_matrix_vector_multiply_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.position      (position),
		.operand_value (operand_value),
		.row_end       (row_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.row_sum       (row_sum),
		.row_number    (row_number)
	);

	always #6 clk = ~clk;

	initial begin
		#10_000_000;
		$display("csr_sparse_matrix_vector_multiply_top: mismatch");
		$finish;
	end

	task automatic flag_fault(input string msg);
		faults++;
		if (faults <= 50) begin
			$display("ERROR t=%0t %s", $time, msg);
		end
	endtask

	// returns 1 when the transaction finishes a row
	function automatic bit spmv_predict(input kind_t k, input logic [POS_W-1:0] p,
			input logic signed [VAL_W-1:0] v, input logic e, output row_result_t res);
		longint             prod;
		logic signed [64:0] wide;
		bit                 emit;
		emit = 1'b0;
		res = '0;
		case (k)
			KIND_LOAD: begin
				vec_shadow[p] = v;
			end
			KIND_NONZERO: begin
				prod = longint'(v) * longint'(vec_shadow[p]);
				wide = {acc_sum[63], acc_sum} + {prod[63], prod};
				if (wide[64] != wide[63]) begin
					acc_sum = wide[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
				end else begin
					acc_sum = wide[63:0];
				end
				emit = e;
			end
			KIND_EMPTY: begin
				emit = 1'b1;
			end
			KIND_NEW: begin
				acc_sum = 0;
				rows_done = 0;
			end
		endcase
		if (emit) begin
			res.sum = acc_sum;
			res.num = rows_done[ROW_NUM_W-1:0];
			acc_sum = 0;
			rows_done = (rows_done == MAX_ROWS - 1) ? 0 : rows_done + 1;
		end
		return emit;
	endfunction

	// entered and left at a falling edge; valid stays high between back-to-back items
	task automatic send_txn(input kind_t k, input logic [POS_W-1:0] p, input logic [VAL_W-1:0] v,
			input logic e, input logic typed = 1'b0, input logic [SUM_W-1:0] t_sum = '0,
			input logic [ROW_NUM_W-1:0] t_num = '0);
		row_result_t res;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= k;
		position      <= p;
		operand_value <= v;
		row_end       <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (k == KIND_LOAD && !vec_written[p]) begin
			vec_written[p] = 1'b1;
			written_cols.push_back(p);
		end
		if (spmv_predict(k, p, v, e, res)) begin
			if (typed) begin
				res.sum = t_sum;
				res.num = t_num;
			end
			pending_rows.push_back(res);
		end
		@(negedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_col();
		return written_cols[$urandom_range(0, written_cols.size() - 1)];
	endfunction

	function automatic logic [VAL_W-1:0] rand_operand();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'h0001_0000;
			4, 5:    return 32'($urandom_range(0, 262143)) - 32'h0002_0000;
			default: return 32'($urandom);
		endcase
	endfunction

	task automatic load_burst(input int n);
		repeat (n) send_txn(KIND_LOAD, POS_W'($urandom), rand_operand(), 1'($urandom));
	endtask

	// any kind with random content; nonzeros only gather written entries
	task automatic noise_txn();
		kind_t k;
		k = kind_t'($urandom_range(0, 3));
		send_txn(k, (k == KIND_NONZERO) ? pick_col() : POS_W'($urandom), 32'($urandom),
			1'($urandom));
	endtask

	task automatic send_row(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 39) == 0) noise_txn();
			send_txn(KIND_NONZERO, pick_col(), rand_operand(), i == len - 1);
		end
	endtask

	task automatic drain_pause();
		in_valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_traffic(input int quota);
		int target;
		int pick;
		target = sent + quota;
		while (sent < target) begin
			if (!tail && $urandom_range(0, 15) == 0) calm = !calm;
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				load_burst($urandom_range(1, 24));
			end else if (pick < 14) begin
				send_txn(KIND_NEW, POS_W'($urandom), 32'($urandom), 1'($urandom));
			end else if (pick < 20) begin
				send_txn(KIND_EMPTY, POS_W'($urandom), 32'($urandom), 1'($urandom));
			end else if (pick < 25) begin
				noise_txn();
			end else if (pick < 27 && !tail) begin
				drain_pause();
			end else begin
				send_row(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6));
			end
		end
	endtask

	// receiver back-pressure in bursts
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		row_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rows.size() == 0) begin
				flag_fault($sformatf("unexpected row %0d sum %h", row_number, row_sum));
			end else begin
				want = pending_rows.pop_front();
				if (row_sum !== want.sum) begin
					flag_fault($sformatf("row %0d row_sum got %h want %h", want.num, row_sum, want.sum));
				end
				if (row_number !== want.num) begin
					flag_fault($sformatf("row_number got %0d want %0d", row_number, want.num));
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = KIND_LOAD;
		position      = '0;
		operand_value = '0;
		row_end       = 1'b0;
		calm          = 1'b0;
		tail          = 1'b0;
		faults        = 0;
		sent          = 0;
		acc_sum       = 0;
		rows_done     = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(negedge clk);

		foreach (check_table[i]) begin
			send_txn(check_table[i].k, check_table[i].p, check_table[i].v, check_table[i].e,
				check_table[i].typed, check_table[i].sum, check_table[i].num);
		end

		load_burst(64);
		random_traffic(900);

		// sender holds off until every expected row has come back
		drain_pause();

		random_traffic(700);
		tail = 1'b1;
		calm = 1'b1;
		random_traffic(250);

		in_valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (faults == 0) begin
			$display("csr_sparse_matrix_vector_multiply_top: match");
		end else begin
			$display("csr_sparse_matrix_vector_multiply_top: mismatch");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/csmv_pkg.sv
design/csmv_ram.sv
design/csmv_front.sv
design/csmv_queue.sv
design/csmv_back.sv
design/csr_sparse_matrix_vector_multiply_top.sv
tb/sv/tb_top.sv
